// File: rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Request and result types, operation codes, status codes and register
// indexes shared by the allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned BytesWidth  = 16;
  localparam int unsigned StrideWidth = 17;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned IndexWidth  = 6;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CfgIdxWidth = 2;

  // operation codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_BAD_ADDR = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_BLOCK_BYTES   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_BLOCKS_IN_USE = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_POOL_BASE     = 2'd2;

  // configuration reset values
  localparam logic [BytesWidth-1:0] BLOCK_BYTES_RST   = 16'd4;
  localparam logic [CountWidth-1:0] BLOCKS_IN_USE_RST = 7'd64;
  localparam logic [AddrWidth-1:0]  POOL_BASE_RST     = 32'd0;

  typedef struct packed {
    logic                 mode;
    logic [AddrWidth-1:0] release_address;
  } req_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [AddrWidth-1:0]   granted_address;
    logic [IndexWidth-1:0]  granted_index;
    logic [CountWidth-1:0]  used_count;
    logic [CountWidth-1:0]  free_space;
  } rsp_t;

endpackage

// File: rtl/fbpa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator configuration registers
// Holds block size, pool size and base address; derives the block stride
// and the pool size clamped to the built maximum.
// ----------------------------------------------------------------------------
module fbpa_cfg_regs #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fbpa_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [fbpa_pkg::AddrWidth-1:0]         cfg_data_i,
  output logic [fbpa_pkg::StrideWidth-1:0]       stride_o,
  output logic [fbpa_pkg::AddrWidth-1:0]         base_o,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]        count_o
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW = CW + fbpa_pkg::CountWidth;

  logic [fbpa_pkg::BytesWidth-1:0]  block_bytes_q;
  logic [fbpa_pkg::CountWidth-1:0]  blocks_in_use_q;
  logic [fbpa_pkg::AddrWidth-1:0]   pool_base_q;
  logic [fbpa_pkg::StrideWidth-1:0] bytes_pad;
  logic [EW-1:0]                    req_ext;
  logic [EW-1:0]                    max_ext;
  logic [EW-1:0]                    eff_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q   <= fbpa_pkg::BLOCK_BYTES_RST;
      blocks_in_use_q <= fbpa_pkg::BLOCKS_IN_USE_RST;
      pool_base_q     <= fbpa_pkg::POOL_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fbpa_pkg::CFG_BLOCK_BYTES:   block_bytes_q   <= cfg_data_i[fbpa_pkg::BytesWidth-1:0];
        fbpa_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data_i[fbpa_pkg::CountWidth-1:0];
        fbpa_pkg::CFG_POOL_BASE:     pool_base_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // round size up to a multiple of four
  assign bytes_pad = {1'b0, block_bytes_q} + fbpa_pkg::StrideWidth'(3);
  assign stride_o  = {bytes_pad[fbpa_pkg::StrideWidth-1:2], 2'b00};
  assign base_o    = pool_base_q;

  assign req_ext = {{CW{1'b0}}, blocks_in_use_q};
  assign max_ext = EW'(MAX_BLOCKS);
  assign eff_ext = (req_ext > max_ext) ? max_ext : req_ext;
  assign count_o = eff_ext[CW-1:0];

endmodule

// File: rtl/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Allocates and frees equal-sized blocks of a pool tracked by used flags.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid_i / in_stall_o / in_data_i) carries an
//    allocate or free request; one transfer happens when valid is high and
//    stall is low. Result channel (out_valid_o / out_stall_i / out_data_o)
//    returns exactly one result per request.
//  - Configuration channel (cfg_valid_i / cfg_ready_o) writes block size,
//    pool size and base address; write only while no request is in flight.
//  - Each request walks the used flags of the configured pool one per cycle
//    with a shared address adder and comparator, counting free blocks on the
//    way. The next request is taken only after the result of the last one
//    has been written to the output register.
//  - in_stall_o is high while a request is being processed.
//  - The result sits in an output register; while out_stall_i holds it, a
//    new request may be taken and scanned, but its result waits until the
//    register is free.
//  - Reset clears all used flags and the used count and restores the
//    configuration to block size 4, 64 blocks, base 0.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fbpa_pkg::req_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fbpa_pkg::rsp_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbpa_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [fbpa_pkg::AddrWidth-1:0]    cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned AW = fbpa_pkg::AddrWidth;
  localparam int unsigned SW = CW + fbpa_pkg::CountWidth;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [fbpa_pkg::StrideWidth-1:0] stride;
  logic [AW-1:0]                    base;
  logic [CW-1:0]                    count;

  logic [1:0]            state_q, state_d;
  logic [MAX_BLOCKS-1:0] flags_q;
  logic [CW-1:0]         total_q;
  logic [CW-1:0]         idx_q;
  logic [CW-1:0]         eff_q;
  logic [AW-1:0]         addr_q;
  logic                  mode_q;
  logic [AW-1:0]         rel_q;
  logic                  found_q;
  logic [IW-1:0]         hit_idx_q;
  logic [AW-1:0]         hit_addr_q;
  logic [CW-1:0]         space_q;
  logic                  out_valid_q;
  fbpa_pkg::rsp_t        out_q;

  logic                  in_xfer;
  logic                  flag;
  logic                  hit;
  logic                  scan_end;
  logic                  slot_free;
  logic [AW-1:0]         addr_next;
  logic [IW+5:0]         gidx_ext;
  logic [SW-1:0]         total_ext;
  logic [SW-1:0]         space_ext;
  logic [CW-1:0]         total_next;

  fbpa_cfg_regs #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stride_o    (stride),
    .base_o      (base),
    .count_o     (count)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // shared datapath: one flag, one address add and compare per cycle
  assign scan_end  = (idx_q == eff_q);
  assign flag      = flags_q[idx_q[IW-1:0]];
  assign addr_next = addr_q + AW'(stride);
  assign hit = !found_q && !scan_end &&
               ((mode_q == fbpa_pkg::MODE_ALLOC) ? !flag : (flag && (addr_q == rel_q)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_SCAN;
      S_SCAN:   if (scan_end) state_d = S_FINISH;
      S_FINISH: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request and scan registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q  <= in_data_i.mode;
      rel_q   <= in_data_i.release_address;
      eff_q   <= count;
      idx_q   <= '0;
      addr_q  <= base;
      found_q <= 1'b0;
      space_q <= '0;
    end else if (state_q == S_SCAN && !scan_end) begin
      idx_q  <= idx_q + CW'(1);
      addr_q <= addr_next;
      if (hit) begin
        found_q    <= 1'b1;
        hit_idx_q  <= idx_q[IW-1:0];
        hit_addr_q <= addr_q;
      end
      // free blocks as they stand after this request
      if (mode_q == fbpa_pkg::MODE_ALLOC) begin
        if (!flag && !hit) space_q <= space_q + CW'(1);
      end else begin
        if (!flag || hit) space_q <= space_q + CW'(1);
      end
    end
  end

  assign total_next = (mode_q == fbpa_pkg::MODE_ALLOC) ? total_q + CW'(1)
                                                       : total_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      total_q <= '0;
    end else if (state_q == S_FINISH && slot_free && found_q) begin
      flags_q[hit_idx_q] <= (mode_q == fbpa_pkg::MODE_ALLOC);
      total_q            <= total_next;
    end
  end

  assign gidx_ext  = {6'b0, hit_idx_q};
  assign total_ext = {{fbpa_pkg::CountWidth{1'b0}}, (found_q ? total_next : total_q)};
  assign space_ext = {{fbpa_pkg::CountWidth{1'b0}}, space_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FINISH && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && slot_free) begin
      if (found_q) begin
        out_q.status <= fbpa_pkg::STATUS_OK;
      end else if (mode_q == fbpa_pkg::MODE_ALLOC) begin
        out_q.status <= fbpa_pkg::STATUS_EMPTY;
      end else begin
        out_q.status <= fbpa_pkg::STATUS_BAD_ADDR;
      end
      out_q.granted_address <= (found_q && mode_q == fbpa_pkg::MODE_ALLOC) ? hit_addr_q : '0;
      out_q.granted_index   <= found_q ? gidx_ext[5:0] : '0;
      out_q.used_count      <= (total_ext > SW'(127)) ? 7'd127 : total_ext[6:0];
      out_q.free_space      <= (space_ext > SW'(127)) ? 7'd127 : space_ext[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate and free requests through the request channel and checks
// every result against a cycle-free model of the used flags. A short table
// covers reset state, empty pools, zero stride, address wrap and a lowered
// block count. Random phases follow; each may write a new configuration.
// Both channels idle at random, and one phase holds the result side off for
// a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_BLOCKS       = 64;
  localparam int unsigned RANDOM_ITEMS     = 1680;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES      = 100;

  typedef enum logic [1:0] {ROW_OPEN, ROW_TYPED, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e                        kind;
    fbpa_pkg::req_t                   req;
    fbpa_pkg::rsp_t                   want;
    logic [fbpa_pkg::CfgIdxWidth-1:0] reg_index;
    logic [fbpa_pkg::AddrWidth-1:0]   reg_value;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  fbpa_pkg::req_t                   in_data_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  fbpa_pkg::rsp_t                   out_data_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [fbpa_pkg::CfgIdxWidth-1:0] cfg_index_i;
  logic [fbpa_pkg::AddrWidth-1:0]   cfg_data_i;

  // model of the pool
  logic                            slot_used [MAX_BLOCKS];
  int unsigned                     slots_taken;
  logic [fbpa_pkg::BytesWidth-1:0] cfg_block_bytes;
  logic [fbpa_pkg::CountWidth-1:0] cfg_block_count;
  logic [fbpa_pkg::AddrWidth-1:0]  cfg_pool_base;

  fbpa_pkg::rsp_t results_due[$];
  int unsigned    error_count;
  int unsigned    quiet_cycles;
  bit             tx_steady;
  bit             rx_steady;
  bit             long_hold_req;

  fixed_block_pool_allocator_unit #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [fbpa_pkg::AddrWidth-1:0] slot_address(input int unsigned idx);
    logic [fbpa_pkg::AddrWidth-1:0] stride;
    stride = ({16'd0, cfg_block_bytes} + 32'd3) & ~32'd3;
    return cfg_pool_base + idx * stride;
  endfunction

  // Applies one request to the model and returns the result it gives.
  function automatic fbpa_pkg::rsp_t pool_outcome(input fbpa_pkg::req_t req);
    int unsigned    span;
    int unsigned    k;
    int unsigned    spare;
    bit             done;
    fbpa_pkg::rsp_t res;
    span = (cfg_block_count > MAX_BLOCKS) ? MAX_BLOCKS : cfg_block_count;
    res = '0;
    done = 1'b0;
    spare = 0;
    for (k = 0; k < span; k++) begin
      if (!done) begin
        if (req.mode == fbpa_pkg::MODE_ALLOC && !slot_used[k]) begin
          slot_used[k] = 1'b1;
          slots_taken++;
          res.granted_address = slot_address(k);
          res.granted_index = fbpa_pkg::IndexWidth'(k);
          done = 1'b1;
        end else if (req.mode == fbpa_pkg::MODE_FREE && slot_used[k] &&
                     slot_address(k) == req.release_address) begin
          slot_used[k] = 1'b0;
          slots_taken--;
          res.granted_index = fbpa_pkg::IndexWidth'(k);
          done = 1'b1;
        end
      end
    end
    if (done) begin
      res.status = fbpa_pkg::STATUS_OK;
    end else begin
      res.status = (req.mode == fbpa_pkg::MODE_ALLOC) ? fbpa_pkg::STATUS_EMPTY
                                                      : fbpa_pkg::STATUS_BAD_ADDR;
    end
    for (k = 0; k < span; k++) begin
      if (!slot_used[k]) spare++;
    end
    res.used_count = fbpa_pkg::CountWidth'(slots_taken);
    res.free_space = fbpa_pkg::CountWidth'(spare);
    return res;
  endfunction

  function automatic fbpa_pkg::req_t random_request(input int unsigned alloc_pct);
    fbpa_pkg::req_t req;
    int unsigned    busy[$];
    int unsigned    k;
    int unsigned    pick;
    req.release_address = $urandom();
    if ($urandom_range(1, 100) <= alloc_pct) begin
      req.mode = fbpa_pkg::MODE_ALLOC;
      return req;
    end
    req.mode = fbpa_pkg::MODE_FREE;
    for (k = 0; k < MAX_BLOCKS; k++) begin
      if (slot_used[k]) busy.push_back(k);
    end
    pick = $urandom_range(0, 19);
    if (pick < 12 && busy.size() > 0) begin
      req.release_address = slot_address(busy[$urandom_range(0, busy.size() - 1)]);
    end else if (pick < 15) begin
      req.release_address = slot_address($urandom_range(0, MAX_BLOCKS - 1));
    end else if (pick < 17 && busy.size() > 0) begin
      // off the block boundary
      req.release_address = slot_address(busy[$urandom_range(0, busy.size() - 1)]) +
                            $urandom_range(1, 3);
    end
    return req;
  endfunction

  function automatic stim_row_t open_row(input logic mode, input logic [31:0] addr);
    stim_row_t row;
    row.kind = ROW_OPEN;
    row.req.mode = mode;
    row.req.release_address = addr;
    row.want = '0;
    row.reg_index = '0;
    row.reg_value = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic mode, input logic [31:0] addr,
                                          input logic [1:0] status, input logic [31:0] gaddr,
                                          input int unsigned gidx, input int unsigned used,
                                          input int unsigned spare);
    stim_row_t row;
    row = open_row(mode, addr);
    row.kind = ROW_TYPED;
    row.want.status = status;
    row.want.granted_address = gaddr;
    row.want.granted_index = fbpa_pkg::IndexWidth'(gidx);
    row.want.used_count = fbpa_pkg::CountWidth'(used);
    row.want.free_space = fbpa_pkg::CountWidth'(spare);
    return row;
  endfunction

  function automatic stim_row_t config_row(input logic [fbpa_pkg::CfgIdxWidth-1:0] idx,
                                           input logic [31:0] value);
    stim_row_t row;
    row = open_row(fbpa_pkg::MODE_ALLOC, '0);
    row.kind = ROW_CONFIG;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  // Returns at the edge of the transfer with valid still high, so the caller
  // either offers the next request or drains in the same step.
  task automatic send_request(input fbpa_pkg::req_t req, input bit typed,
                              input fbpa_pkg::rsp_t typed_rsp);
    int unsigned    gap;
    fbpa_pkg::rsp_t predicted;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted = pool_outcome(req);
    results_due.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [fbpa_pkg::CfgIdxWidth-1:0] idx,
                                input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      fbpa_pkg::CFG_BLOCK_BYTES:   cfg_block_bytes = value[fbpa_pkg::BytesWidth-1:0];
      fbpa_pkg::CFG_BLOCKS_IN_USE: cfg_block_count = value[fbpa_pkg::CountWidth-1:0];
      fbpa_pkg::CFG_POOL_BASE:     cfg_pool_base = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // result side: random stall before each transfer, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD_CYCLES;
      end else begin
        hold = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin : result_check
    fbpa_pkg::rsp_t want;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            error_count++;
          end
          if (out_data_o.granted_address !== want.granted_address) begin
            $error("granted_address: expected %h, got %h",
                   want.granted_address, out_data_o.granted_address);
            error_count++;
          end
          if (out_data_o.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, out_data_o.granted_index);
            error_count++;
          end
          if (out_data_o.used_count !== want.used_count) begin
            $error("used_count: expected %0d, got %0d", want.used_count, out_data_o.used_count);
            error_count++;
          end
          if (out_data_o.free_space !== want.free_space) begin
            $error("free_space: expected %0d, got %0d", want.free_space, out_data_o.free_space);
            error_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   directed_rows[$];
    int unsigned random_items;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned alloc_pct;
    int unsigned sel;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    slots_taken     = 0;
    cfg_block_bytes = fbpa_pkg::BLOCK_BYTES_RST;
    cfg_block_count = fbpa_pkg::BLOCKS_IN_USE_RST;
    cfg_pool_base   = fbpa_pkg::POOL_BASE_RST;
    error_count     = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    long_hold_req   = 1'b0;

    // reset configuration: stride 4, 64 blocks, base 0
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'h0,
                                      fbpa_pkg::STATUS_BAD_ADDR, 32'h0, 0, 0, 64));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_OK, 32'h0, 0, 1, 63));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_OK, 32'h4, 1, 2, 62));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'h4,
                                      fbpa_pkg::STATUS_OK, 32'h0, 1, 1, 63));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'h4,
                                      fbpa_pkg::STATUS_BAD_ADDR, 32'h0, 0, 1, 63));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFF,
                                      fbpa_pkg::STATUS_BAD_ADDR, 32'h0, 0, 1, 63));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'h0,
                                      fbpa_pkg::STATUS_OK, 32'h0, 0, 0, 64));
    // empty pool
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCKS_IN_USE, 32'd0));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_EMPTY, 32'h0, 0, 0, 0));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'h0,
                                      fbpa_pkg::STATUS_BAD_ADDR, 32'h0, 0, 0, 0));
    // zero stride: every block at the base
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCK_BYTES, 32'd0));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCKS_IN_USE, 32'd2));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_POOL_BASE, 32'hFFFF_FFFF));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_OK, 32'hFFFF_FFFF, 0, 1, 1));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_OK, 32'hFFFF_FFFF, 1, 2, 0));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_ALLOC, 32'h0,
                                      fbpa_pkg::STATUS_EMPTY, 32'h0, 0, 2, 0));
    directed_rows.push_back(typed_row(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFF,
                                      fbpa_pkg::STATUS_OK, 32'h0, 0, 1, 1));
    // largest stride, addresses wrap past the top, count above the maximum
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCK_BYTES, 32'd65535));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_POOL_BASE, 32'hFFFE_0000));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCKS_IN_USE, 32'd127));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_ALLOC, 32'h0));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_ALLOC, 32'h0));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'h0));
    // count lowered under a used block
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCKS_IN_USE, 32'd1));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_ALLOC, 32'h0));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'hFFFF_0000));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'hFFFE_0000));
    // size padding
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCK_BYTES, 32'd1));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_POOL_BASE, 32'h0));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCKS_IN_USE, 32'd64));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'h4));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_ALLOC, 32'hFFFF_FFFF));
    directed_rows.push_back(config_row(fbpa_pkg::CFG_BLOCK_BYTES, 32'd5));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_ALLOC, 32'h0));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'h8));
    directed_rows.push_back(open_row(fbpa_pkg::MODE_FREE, 32'h0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          drain_requests();
          write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
        end
        ROW_TYPED: send_request(directed_rows[i].req, 1'b1, directed_rows[i].want);
        default:   send_request(directed_rows[i].req, 1'b0, '0);
      endcase
    end

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_requests();
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 7);
        write_register(fbpa_pkg::CFG_BLOCK_BYTES, (sel == 0) ? 32'd0 :
                                                  (sel == 1) ? 32'd65535 :
                                                  (sel == 2) ? $urandom_range(0, 65535) :
                                                               $urandom_range(1, 12));
      end
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 19);
        write_register(fbpa_pkg::CFG_BLOCKS_IN_USE, (sel == 0) ? 32'd0 :
                                                    (sel == 1) ? 32'd64 :
                                                    (sel == 2) ? $urandom_range(65, 127) :
                                                    (sel == 3) ? 32'd1 :
                                                                 $urandom_range(1, 16));
      end
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 3);
        write_register(fbpa_pkg::CFG_POOL_BASE,
                       (sel == 0) ? 32'd0 :
                       (sel == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255) :
                                    $urandom());
      end
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      if (phase == 2) begin
        // back the block up behind a held result
        long_hold_req = 1'b1;
        tx_steady = 1'b1;
      end
      alloc_pct = $urandom_range(25, 75);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        send_request(random_request(alloc_pct), 1'b0, '0);
        random_items++;
        if ($urandom_range(0, 63) == 0) drain_requests();
      end
      phase++;
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
